// ===== rtl/core/tdsm_pkg.sv =====
// Shared types and constants for the two-wire display serial master.
package tdsm_pkg;

   // Number of segment bytes sent after the start address.
   localparam int unsigned DIGITS = 6;

   // Field and register widths.
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned SEG_W      = 48;
   localparam int unsigned BRIGHT_W   = 3;
   localparam int unsigned TIMEOUT_W  = 13;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned BIT_CNT_W  = 4;
   localparam int unsigned BYTE_IDX_W = 3;

   // Reset values of the configuration registers.
   localparam logic [BRIGHT_W-1:0]  BRIGHTNESS_RST    = 3'd7;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST   = 13'd5000;
   localparam logic [BYTE_W-1:0]    DATA_COMMAND_RST  = 8'h40;
   localparam logic [BYTE_W-1:0]    START_ADDRESS_RST = 8'hC0;

   // Upper five bits of the display-control byte (display on).
   localparam logic [BYTE_W-BRIGHT_W-1:0] DISPLAY_ON_HI = 5'b10001;

   // Request codes carried by each input word.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 2'd0,
      MODE_FRAME   = 2'd1,
      MODE_CONTROL = 2'd2
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BRIGHTNESS    = 2'd0,
      CSR_ACK_TIMEOUT   = 2'd1,
      CSR_DATA_COMMAND  = 2'd2,
      CSR_START_ADDRESS = 2'd3
   } csr_index_type;

   // Waveform phases, one-hot.
   typedef enum logic [11:0] {
      PH_IDLE     = 12'b0000_0000_0001,
      PH_ST_A     = 12'b0000_0000_0010,
      PH_ST_B     = 12'b0000_0000_0100,
      PH_BIT_LO   = 12'b0000_0000_1000,
      PH_BIT_HI   = 12'b0000_0001_0000,
      PH_ACK_LO   = 12'b0000_0010_0000,
      PH_ACK_WAIT = 12'b0000_0100_0000,
      PH_SP_A     = 12'b0000_1000_0000,
      PH_SP_B     = 12'b0001_0000_0000,
      PH_SP_C     = 12'b0010_0000_0000,
      PH_FSP_B    = 12'b0100_0000_0000,
      PH_FSP_C    = 12'b1000_0000_0000
   } phase_type;

endpackage

// ===== rtl/core/two_wire_display_serial_master.sv =====
// Two-wire display serial master: start/stop framing, LSB-first bytes, acknowledge wait.
//
// Each request word is one delay interval of the pin waveform and yields exactly one
// response word with the clock and data pin levels for that interval plus busy, done and
// acknowledge-failure status. A word is taken every cycle as long as the response register
// is empty or being read in the same cycle; the one phase register update per word sets
// this rate. When idle, a frame request (data command, start address with six segment
// bytes, display control) or a display-control request starts its sequence on the same
// word. After each byte the block samples the data line once per word until it reads low;
// once more high samples than the acknowledge timeout have been seen, it sends a stop and
// finishes flagged as failed. User must write configuration only while idle, unenforced.
module two_wire_display_serial_master (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tdsm_pkg::MODE_W-1:0]         req_mode,
   input  logic [tdsm_pkg::SEG_W-1:0]          req_segments,
   input  logic                                req_dio_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_clk_level,
   output logic                                rsp_dio_released,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_ack_fail,
   // configuration port
   input  logic                                csr_we,
   input  logic [tdsm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tdsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [tdsm_pkg::BRIGHT_W-1:0]   brightness_ff;
   logic [tdsm_pkg::TIMEOUT_W-1:0]  ack_timeout_ff;
   logic [tdsm_pkg::BYTE_W-1:0]     data_command_ff;
   logic [tdsm_pkg::BYTE_W-1:0]     start_address_ff;

   // Sequencer state.
   tdsm_pkg::phase_type             phase_ff, phase_in;
   logic [tdsm_pkg::BIT_CNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [tdsm_pkg::BYTE_IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [tdsm_pkg::BYTE_W-1:0]     shift_byte_ff, shift_byte_in;
   logic [tdsm_pkg::SEG_W-1:0]      frame_store_ff, frame_store_in;
   logic [tdsm_pkg::TIMEOUT_W-1:0]  wait_count_ff, wait_count_in;
   logic                            request_kind_ff, request_kind_in;
   logic                            clock_pin_ff, clock_pin_in;
   logic                            data_pin_ff, data_pin_in;

   // Response register.
   logic                            rsp_valid_ff;
   logic                            rsp_clk_ff, rsp_dio_ff, rsp_busy_ff, rsp_done_ff;
   logic                            rsp_fail_ff;
   logic                            busy_in, done_in, fail_in;

   logic                            req_fire;
   tdsm_pkg::phase_type             ph_start;
   logic [tdsm_pkg::BYTE_IDX_W-1:0] next_index;
   logic [tdsm_pkg::BYTE_IDX_W-1:0] seg_slot;
   logic [tdsm_pkg::BYTE_W-1:0]     seg_sel;
   logic [tdsm_pkg::BIT_CNT_W-1:0]  bit_count_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff    <= tdsm_pkg::BRIGHTNESS_RST;
         ack_timeout_ff   <= tdsm_pkg::ACK_TIMEOUT_RST;
         data_command_ff  <= tdsm_pkg::DATA_COMMAND_RST;
         start_address_ff <= tdsm_pkg::START_ADDRESS_RST;
      end else if (csr_we) begin
         unique case (tdsm_pkg::csr_index_type'(csr_addr))
            tdsm_pkg::CSR_BRIGHTNESS:
               brightness_ff <= csr_wdata[tdsm_pkg::BRIGHT_W-1:0];
            tdsm_pkg::CSR_ACK_TIMEOUT:
               ack_timeout_ff <= csr_wdata[tdsm_pkg::TIMEOUT_W-1:0];
            tdsm_pkg::CSR_DATA_COMMAND:
               data_command_ff <= csr_wdata[tdsm_pkg::BYTE_W-1:0];
            tdsm_pkg::CSR_START_ADDRESS:
               start_address_ff <= csr_wdata[tdsm_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Next segment byte: the index after increment runs from two up, segment zero first.
   assign next_index    = byte_index_ff + 3'd1;
   assign seg_slot      = next_index - 3'd2;
   assign bit_count_inc = bit_count_ff + 4'd1;

   always_comb begin
      unique case (seg_slot)
         3'd0:    seg_sel = frame_store_ff[7:0];
         3'd1:    seg_sel = frame_store_ff[15:8];
         3'd2:    seg_sel = frame_store_ff[23:16];
         3'd3:    seg_sel = frame_store_ff[31:24];
         3'd4:    seg_sel = frame_store_ff[39:32];
         3'd5:    seg_sel = frame_store_ff[47:40];
         default: seg_sel = '0;
      endcase
   end

   // One waveform interval: request pickup, then the phase step.
   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      byte_index_in   = byte_index_ff;
      shift_byte_in   = shift_byte_ff;
      frame_store_in  = frame_store_ff;
      wait_count_in   = wait_count_ff;
      request_kind_in = request_kind_ff;
      clock_pin_in    = clock_pin_ff;
      data_pin_in     = data_pin_ff;
      busy_in         = 1'b1;
      done_in         = 1'b0;
      fail_in         = 1'b0;
      ph_start        = phase_ff;

      if (phase_ff == tdsm_pkg::PH_IDLE) begin
         if (req_mode == tdsm_pkg::MODE_FRAME) begin
            frame_store_in  = req_segments;
            request_kind_in = 1'b1;
            byte_index_in   = '0;
            ph_start        = tdsm_pkg::PH_ST_A;
         end else if (req_mode == tdsm_pkg::MODE_CONTROL) begin
            request_kind_in = 1'b0;
            byte_index_in   = '0;
            ph_start        = tdsm_pkg::PH_ST_A;
         end
      end

      unique case (ph_start)
         tdsm_pkg::PH_IDLE: begin
            busy_in = 1'b0;
         end
         tdsm_pkg::PH_ST_A: begin
            clock_pin_in = 1'b1;
            data_pin_in  = 1'b1;
            phase_in     = tdsm_pkg::PH_ST_B;
         end
         tdsm_pkg::PH_ST_B: begin
            clock_pin_in = 1'b1;
            data_pin_in  = 1'b0;
            if (!request_kind_ff) begin
               shift_byte_in = {tdsm_pkg::DISPLAY_ON_HI, brightness_ff};
            end else if (byte_index_ff == '0) begin
               shift_byte_in = data_command_ff;
            end else begin
               shift_byte_in = start_address_ff;
            end
            bit_count_in = '0;
            phase_in     = tdsm_pkg::PH_BIT_LO;
         end
         tdsm_pkg::PH_BIT_LO: begin
            clock_pin_in = 1'b0;
            data_pin_in  = shift_byte_ff[0];
            phase_in     = tdsm_pkg::PH_BIT_HI;
         end
         tdsm_pkg::PH_BIT_HI: begin
            clock_pin_in  = 1'b1;
            data_pin_in   = shift_byte_ff[0];
            shift_byte_in = {1'b0, shift_byte_ff[tdsm_pkg::BYTE_W-1:1]};
            bit_count_in  = bit_count_inc;
            phase_in      = (bit_count_inc >= 4'd8) ? tdsm_pkg::PH_ACK_LO
                                                    : tdsm_pkg::PH_BIT_LO;
         end
         tdsm_pkg::PH_ACK_LO: begin
            clock_pin_in  = 1'b0;
            data_pin_in   = 1'b1;
            wait_count_in = '0;
            phase_in      = tdsm_pkg::PH_ACK_WAIT;
         end
         tdsm_pkg::PH_ACK_WAIT: begin
            // Acknowledge seen, timed out, or keep waiting.
            if (!req_dio_in) begin
               clock_pin_in = 1'b1;
               data_pin_in  = 1'b1;
               if (request_kind_ff && byte_index_ff != '0 &&
                   byte_index_ff < tdsm_pkg::BYTE_IDX_W'(tdsm_pkg::DIGITS + 1)) begin
                  byte_index_in = next_index;
                  shift_byte_in = seg_sel;
                  bit_count_in  = '0;
                  phase_in      = tdsm_pkg::PH_BIT_LO;
               end else begin
                  phase_in = tdsm_pkg::PH_SP_A;
               end
            end else if (wait_count_ff >= ack_timeout_ff) begin
               clock_pin_in = 1'b0;
               data_pin_in  = 1'b0;
               phase_in     = tdsm_pkg::PH_FSP_B;
            end else begin
               clock_pin_in  = 1'b0;
               data_pin_in   = 1'b1;
               wait_count_in = wait_count_ff + 13'd1;
            end
         end
         tdsm_pkg::PH_SP_A: begin
            clock_pin_in = 1'b0;
            data_pin_in  = 1'b0;
            phase_in     = tdsm_pkg::PH_SP_B;
         end
         tdsm_pkg::PH_SP_B: begin
            clock_pin_in = 1'b1;
            data_pin_in  = 1'b0;
            phase_in     = tdsm_pkg::PH_SP_C;
         end
         tdsm_pkg::PH_SP_C: begin
            // End of one part: move to the next part of a frame or finish.
            clock_pin_in = 1'b1;
            data_pin_in  = 1'b1;
            if (request_kind_ff) begin
               if (byte_index_ff == '0) begin
                  byte_index_in = 3'd1;
               end else begin
                  request_kind_in = 1'b0;
                  byte_index_in   = '0;
               end
               phase_in = tdsm_pkg::PH_ST_A;
            end else begin
               done_in  = 1'b1;
               phase_in = tdsm_pkg::PH_IDLE;
            end
         end
         tdsm_pkg::PH_FSP_B: begin
            clock_pin_in = 1'b1;
            data_pin_in  = 1'b0;
            phase_in     = tdsm_pkg::PH_FSP_C;
         end
         tdsm_pkg::PH_FSP_C: begin
            // Last stop tick of a timed-out sequence finishes with the failure flag.
            clock_pin_in = 1'b1;
            data_pin_in  = 1'b1;
            done_in      = 1'b1;
            fail_in      = 1'b1;
            phase_in     = tdsm_pkg::PH_IDLE;
         end
         default: begin
            phase_in = tdsm_pkg::PH_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State update, one step per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= tdsm_pkg::PH_IDLE;
         bit_count_ff    <= '0;
         byte_index_ff   <= '0;
         shift_byte_ff   <= '0;
         wait_count_ff   <= '0;
         request_kind_ff <= 1'b0;
         clock_pin_ff    <= 1'b0;
         data_pin_ff     <= 1'b1;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         byte_index_ff   <= byte_index_in;
         shift_byte_ff   <= shift_byte_in;
         wait_count_ff   <= wait_count_in;
         request_kind_ff <= request_kind_in;
         clock_pin_ff    <= clock_pin_in;
         data_pin_ff     <= data_pin_in;
      end
   end

   // Frame store holds payload only.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_store_ff <= frame_store_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_clk_ff  <= clock_pin_in;
         rsp_dio_ff  <= data_pin_in;
         rsp_busy_ff <= busy_in;
         rsp_done_ff <= done_in;
         rsp_fail_ff <= fail_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clk_level    = rsp_clk_ff;
   assign rsp_dio_released = rsp_dio_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_ack_fail     = rsp_fail_ff;

`ifndef SYNTHESIS
   // A failure is only reported on the finishing word of a busy sequence.
   a_fail_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_fail |-> rsp_done_res && rsp_busy_res)
      else $error("ack_fail without done");

   // A plain tick while idle leaves the sequencer idle.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == tdsm_pkg::PH_IDLE &&
      req_mode != tdsm_pkg::MODE_FRAME && req_mode != tdsm_pkg::MODE_CONTROL
      |=> phase_ff == tdsm_pkg::PH_IDLE && !rsp_busy_res)
      else $error("idle tick started a sequence");

   // The bit counter never passes one byte.
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter overflow");

   // The byte index never passes the last segment byte.
   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= tdsm_pkg::BYTE_IDX_W'(tdsm_pkg::DIGITS + 1))
      else $error("byte index overflow");
`endif

endmodule
